/* rtl/core/dtsm_pkg.sv */
// ----------------------------------------------------------------------------
// dtsm_pkg
// Shared types and constants of the dual temperature sensor monitor.
// ----------------------------------------------------------------------------
package dtsm_pkg;

  // Monitor state codes
  typedef enum logic [1:0] {
    ST_INITIAL      = 2'd0,
    ST_TIMEOUT      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_READY        = 2'd3
  } state_e;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SENSORS_REQUIRED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP_C        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF_ENTER_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF_RECOVER_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS        = 3'd4;

  typedef struct packed {
    logic              sensors_required;
    logic signed [8:0] max_temp_c;
    logic [8:0]        max_diff_enter_c;
    logic [8:0]        max_diff_recover_c;
    logic [15:0]       timeout_ms;
  } cfg_t;

  localparam logic              RST_SENSORS_REQUIRED = 1'b0;
  localparam logic signed [8:0] RST_MAX_TEMP_C       = 9'sd120;
  localparam logic [8:0]        RST_MAX_DIFF_ENTER_C = 9'd5;
  localparam logic [8:0]        RST_MAX_DIFF_RECOVER_C = 9'd5;
  localparam logic [15:0]       RST_TIMEOUT_MS       = 16'd5000;

  // Input payload, last field in the lowest bits
  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] temp_b_c;
    logic signed [15:0] temp_a_c;
  } in_data_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic               temp_ok;
    logic               available_or_optional;
    logic               overheat_error;
    logic               sensor_fail_error;
    logic signed [15:0] temp_b_now;
    logic signed [15:0] temp_a_now;
    state_e             monitor_state;
  } res_t;

  localparam int IN_TDATA_W  = 64;
  localparam int RES_W       = $bits(res_t);
  localparam int OUT_TDATA_W = 40;

  // Temperature arithmetic width: holds any stored reading and its differences
  localparam int WIDE_W = 34;

  localparam int                       TEMP_UNAVAIL     = -99;
  localparam logic signed [15:0]       TEMP_UNAVAIL_OUT = -16'sd99;
  localparam logic signed [WIDE_W-1:0] RANGE_LOW_W      = -34'sd40;
  localparam logic signed [WIDE_W-1:0] RANGE_HIGH_W     = 34'sd250;

endpackage

/* rtl/core/dtsm_cfg.sv */
// ----------------------------------------------------------------------------
// dtsm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dtsm_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dtsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dtsm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output dtsm_pkg::cfg_t                   cfg_o
);

  dtsm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dtsm_pkg::CFG_SENSORS_REQUIRED:   cfg_d.sensors_required   = cfg_wdata_i[0];
        dtsm_pkg::CFG_MAX_TEMP_C:         cfg_d.max_temp_c         = signed'(cfg_wdata_i[8:0]);
        dtsm_pkg::CFG_MAX_DIFF_ENTER_C:   cfg_d.max_diff_enter_c   = cfg_wdata_i[8:0];
        dtsm_pkg::CFG_MAX_DIFF_RECOVER_C: cfg_d.max_diff_recover_c = cfg_wdata_i[8:0];
        dtsm_pkg::CFG_TIMEOUT_MS:         cfg_d.timeout_ms         = cfg_wdata_i[15:0];
        default:                          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensors_required   <= dtsm_pkg::RST_SENSORS_REQUIRED;
      cfg_q.max_temp_c         <= dtsm_pkg::RST_MAX_TEMP_C;
      cfg_q.max_diff_enter_c   <= dtsm_pkg::RST_MAX_DIFF_ENTER_C;
      cfg_q.max_diff_recover_c <= dtsm_pkg::RST_MAX_DIFF_RECOVER_C;
      cfg_q.timeout_ms         <= dtsm_pkg::RST_TIMEOUT_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/dtsm_eval.sv */
// ----------------------------------------------------------------------------
// dtsm_eval
// Single-pass evaluation of one item: next monitor state, stored values and
// the result fields.
// ----------------------------------------------------------------------------
module dtsm_eval #(
  parameter int TIME_WIDTH = 32,
  parameter int TEMP_WIDTH = 16
) (
  input  dtsm_pkg::cfg_t                 cfg_i,
  input  logic                           mode_i,
  input  dtsm_pkg::in_data_t             data_i,
  input  dtsm_pkg::state_e               state_q_i,
  input  logic signed [TEMP_WIDTH-1:0]   temp_a_q_i,
  input  logic signed [TEMP_WIDTH-1:0]   temp_b_q_i,
  input  logic [TIME_WIDTH-1:0]          last_q_i,
  output dtsm_pkg::state_e               state_d_o,
  output logic signed [TEMP_WIDTH-1:0]   temp_a_d_o,
  output logic signed [TEMP_WIDTH-1:0]   temp_b_d_o,
  output logic [TIME_WIDTH-1:0]          last_d_o,
  output dtsm_pkg::res_t                 res_o
);

  localparam int WW = dtsm_pkg::WIDE_W;
  localparam logic signed [WW-1:0] SAT_HI =
    WW'((longint'(1) <<< (TEMP_WIDTH - 1)) - longint'(1));
  localparam logic signed [WW-1:0] SAT_LO =
    WW'(-(longint'(1) <<< (TEMP_WIDTH - 1)));
  localparam logic signed [TEMP_WIDTH-1:0] TEMP_UNAVAIL_T =
    TEMP_WIDTH'(dtsm_pkg::TEMP_UNAVAIL);

  function automatic logic out_of_range(input logic signed [WW-1:0] a,
                                        input logic signed [WW-1:0] b,
                                        input logic [8:0]           lim);
    logic signed [WW-1:0] lim_w;
    logic signed [WW-1:0] dab;
    logic signed [WW-1:0] dba;
    lim_w = {{(WW-9){1'b0}}, lim};
    dab   = a - b;
    dba   = b - a;
    return (a < dtsm_pkg::RANGE_LOW_W) || (a > dtsm_pkg::RANGE_HIGH_W) ||
           (b < dtsm_pkg::RANGE_LOW_W) || (b > dtsm_pkg::RANGE_HIGH_W) ||
           (dab > lim_w) || (dba > lim_w);
  endfunction

  logic signed [WW-1:0]         in_a_w, in_b_w, sat_a_w, sat_b_w;
  logic signed [WW-1:0]         max_w, nxt_a_w, nxt_b_w;
  logic [TIME_WIDTH+31:0]       now_ext;
  logic [TIME_WIDTH-1:0]        now_t, gap_fwd, gap_bwd, gap_mag, tmo_w;
  logic [8:0]                   diff_lim;
  logic                         msg_bad;
  logic                         tick_active;
  logic                         timed_out;

  // Saturate the incoming readings to the stored width
  assign in_a_w  = {{(WW-16){data_i.temp_a_c[15]}}, data_i.temp_a_c};
  assign in_b_w  = {{(WW-16){data_i.temp_b_c[15]}}, data_i.temp_b_c};
  assign sat_a_w = (in_a_w > SAT_HI) ? SAT_HI : ((in_a_w < SAT_LO) ? SAT_LO : in_a_w);
  assign sat_b_w = (in_b_w > SAT_HI) ? SAT_HI : ((in_b_w < SAT_LO) ? SAT_LO : in_b_w);
  assign max_w   = {{(WW-9){cfg_i.max_temp_c[8]}}, cfg_i.max_temp_c};

  assign diff_lim = (state_q_i == dtsm_pkg::ST_OUT_OF_RANGE) ?
                    cfg_i.max_diff_recover_c : cfg_i.max_diff_enter_c;
  assign msg_bad  = out_of_range(sat_a_w, sat_b_w, diff_lim);

  // Time gap taken modulo the time width, magnitude of its signed value
  assign now_ext     = {{TIME_WIDTH{1'b0}}, data_i.now_ms};
  assign now_t       = now_ext[TIME_WIDTH-1:0];
  assign gap_fwd     = now_t - last_q_i;
  assign gap_bwd     = last_q_i - now_t;
  assign gap_mag     = gap_fwd[TIME_WIDTH-1] ? gap_bwd : gap_fwd;
  assign tmo_w       = TIME_WIDTH'(cfg_i.timeout_ms);
  assign tick_active = (state_q_i == dtsm_pkg::ST_OUT_OF_RANGE) ||
                       (state_q_i == dtsm_pkg::ST_READY);
  assign timed_out   = mode_i && tick_active && (gap_mag > tmo_w);

  // Next state and stored values
  always_comb begin
    state_d_o  = state_q_i;
    temp_a_d_o = temp_a_q_i;
    temp_b_d_o = temp_b_q_i;
    last_d_o   = last_q_i;
    if (!mode_i) begin
      temp_a_d_o = sat_a_w[TEMP_WIDTH-1:0];
      temp_b_d_o = sat_b_w[TEMP_WIDTH-1:0];
      last_d_o   = now_t;
      state_d_o  = msg_bad ? dtsm_pkg::ST_OUT_OF_RANGE : dtsm_pkg::ST_READY;
    end else if (timed_out) begin
      temp_a_d_o = TEMP_UNAVAIL_T;
      temp_b_d_o = TEMP_UNAVAIL_T;
      last_d_o   = '0;
      state_d_o  = dtsm_pkg::ST_TIMEOUT;
    end
  end

  assign nxt_a_w = {{(WW-TEMP_WIDTH){temp_a_d_o[TEMP_WIDTH-1]}}, temp_a_d_o};
  assign nxt_b_w = {{(WW-TEMP_WIDTH){temp_b_d_o[TEMP_WIDTH-1]}}, temp_b_d_o};

  // Result fields; all but the two error flags are taken from the state after the step
  always_comb begin
    res_o.monitor_state         = state_d_o;
    res_o.temp_a_now            = nxt_a_w[15:0];
    res_o.temp_b_now            = nxt_b_w[15:0];
    res_o.sensor_fail_error     = timed_out && cfg_i.sensors_required;
    res_o.overheat_error        = !mode_i && cfg_i.sensors_required &&
                                  ((sat_a_w > max_w) || (sat_b_w > max_w));
    res_o.available_or_optional = !cfg_i.sensors_required ||
                                  (state_d_o == dtsm_pkg::ST_READY);
    res_o.temp_ok               = !(nxt_a_w > max_w) && !(nxt_b_w > max_w) &&
                                  (state_d_o != dtsm_pkg::ST_OUT_OF_RANGE) &&
                                  res_o.available_or_optional;
  end

endmodule

/* rtl/core/dual_temp_sensor_monitor_unit.sv */
// ----------------------------------------------------------------------------
// dual_temp_sensor_monitor_unit
// Validity monitor for a pair of external temperature sensors.
// ----------------------------------------------------------------------------
// Each input transfer is a reading message (tuser low) or a tick (tuser high)
// and yields exactly one result transfer. The unit takes one item per clock
// while s_axis_tready is high: an item is held in the input register, is
// evaluated in a single pass against the stored monitor state and lands in
// the result register, from which its result is presented. The result
// register lets a new item in while an earlier result waits;
// s_axis_tready drops only when both registers are full and the output is
// stalled. Write the configuration only while no item is pending.
module dual_temp_sensor_monitor_unit #(
  parameter int TIME_WIDTH = 32,
  parameter int TEMP_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dtsm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dtsm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // temp_a_c[15:0], temp_b_c[31:16], now_ms[63:32]
  input  logic [dtsm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode: 0 message, 1 tick
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // monitor_state[1:0], temp_a_now[17:2], temp_b_now[33:18],
  // sensor_fail_error[34], overheat_error[35], available_or_optional[36],
  // temp_ok[37], zero[39:38]
  output logic [dtsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  dtsm_pkg::cfg_t                cfg;
  logic                          in_valid_q;
  logic                          in_mode_q;
  dtsm_pkg::in_data_t            in_data_q;
  logic                          out_valid_q;
  dtsm_pkg::res_t                res_q, res_d;
  dtsm_pkg::state_e              state_q, state_d;
  logic signed [TEMP_WIDTH-1:0]  temp_a_q, temp_a_d, temp_b_q, temp_b_d;
  logic [TIME_WIDTH-1:0]         last_q, last_d;
  logic                          advance;

  dtsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dtsm_eval #(
    .TIME_WIDTH (TIME_WIDTH),
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_eval (
    .cfg_i      (cfg),
    .mode_i     (in_mode_q),
    .data_i     (in_data_q),
    .state_q_i  (state_q),
    .temp_a_q_i (temp_a_q),
    .temp_b_q_i (temp_b_q),
    .last_q_i   (last_q),
    .state_d_o  (state_d),
    .temp_a_d_o (temp_a_d),
    .temp_b_d_o (temp_b_d),
    .last_d_o   (last_d),
    .res_o      (res_d)
  );

  // Move the held item into the result register when that register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= dtsm_pkg::ST_INITIAL;
      temp_a_q    <= TEMP_WIDTH'(dtsm_pkg::TEMP_UNAVAIL);
      temp_b_q    <= TEMP_WIDTH'(dtsm_pkg::TEMP_UNAVAIL);
      last_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        temp_a_q    <= temp_a_d;
        temp_b_q    <= temp_b_d;
        last_q      <= last_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(dtsm_pkg::OUT_TDATA_W - dtsm_pkg::RES_W){1'b0}}, res_q};

endmodule

/* rtl/core/dtsm_checker.sv */
// ----------------------------------------------------------------------------
// dtsm_checker
// Port-level checks of the dual temperature sensor monitor.
// ----------------------------------------------------------------------------
module dtsm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dtsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  dtsm_pkg::res_t res;

  assign res = m_axis_tdata[dtsm_pkg::RES_W-1:0];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An empty result register never backs up the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // No stored reading outside ready and out-of-range
  a_unavail_temps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.monitor_state == dtsm_pkg::ST_INITIAL ||
                      res.monitor_state == dtsm_pkg::ST_TIMEOUT)
    |-> res.temp_a_now == dtsm_pkg::TEMP_UNAVAIL_OUT &&
        res.temp_b_now == dtsm_pkg::TEMP_UNAVAIL_OUT)
    else $error("temperature shown while unavailable");

  // A fail pulse comes only with entry into timeout
  a_fail_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.sensor_fail_error
    |-> res.monitor_state == dtsm_pkg::ST_TIMEOUT)
    else $error("fail pulse outside timeout");

  // OK implies available and in range
  a_ok_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.temp_ok
    |-> res.available_or_optional &&
        res.monitor_state != dtsm_pkg::ST_OUT_OF_RANGE)
    else $error("temp_ok without availability");

endmodule

bind dual_temp_sensor_monitor_unit dtsm_checker u_dtsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
